// ===== rtl/bnpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus node presence table package
// Shared types, codes and constants for the presence table unit.
// ----------------------------------------------------------------------------
package bnpt_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
	localparam logic [7:0] HIGHEST_NODE_ID = 8'd127;

	typedef enum logic [1:0] {
		MODE_STATUS = 2'd0,
		MODE_CAPS   = 2'd1,
		MODE_SWEEP  = 2'd2,
		MODE_LOOKUP = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_CREATE,
		ST_UPDATE,
		ST_SW_RD,
		ST_SW_CMP,
		ST_MV_RD,
		ST_MV_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [6:0]  id;
		logic [31:0] seen;
		logic [15:0] caps;
		logic [1:0]  health;
		logic [2:0]  opm;
		logic [15:0] vendor;
		logic [31:0] uptime;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic rd_last;
		logic inc_idx;
		logic sw_remove;
		logic take_hit;
		logic take_new;
		logic wr_upd;
		logic wr_move;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  scan_end;
		logic  id_match;
		logic  expired;
		logic  idx_is_last;
		logic  can_create;
		logic  out_busy;
	} sts_t;

endpackage

// ===== rtl/bus_node_presence_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus node presence table unit
// Each transaction reads and compares the slots in turn. A lookup stops on a
// hit; status and caps modes update the matching slot, or on a miss create an
// entry if the id is valid and a slot is free. A sweep refills each expired
// slot with the last entry, or drops it if it is the last. One transaction at
// a time; a result not yet taken holds the next transaction in its last state.
// Reset: table empty, timeout 5000 ms; entry memory is not cleared.
// ----------------------------------------------------------------------------
module bus_node_presence_table_unit
	import bnpt_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// node_id, now_ms, capability, health, op_mode, uptime, vendor_code, pad
	input  logic [111:0] s_tdata,
	// mode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// slot, node_count, removed_count, entry_health, entry_mode, entry_uptime,
	// entry_vendor, entry_caps, entry_last_seen, pad
	output logic [119:0] m_tdata,
	// hit
	output logic         m_tuser,
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	bnpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bnpt_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ===== rtl/bnpt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Presence table controller
// Sequences slot scans, entry creation, updates and the expiry sweep.
// ----------------------------------------------------------------------------
module bnpt_ctrl
	import bnpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (sts.scan_end) begin
					if (sts.mode != MODE_LOOKUP && sts.can_create) begin
						state_d = ST_CREATE;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (sts.id_match) begin
					state_d = (sts.mode == MODE_LOOKUP) ? ST_DONE : ST_UPDATE;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_CREATE: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DONE;
			ST_SW_RD: begin
				state_d = sts.scan_end ? ST_DONE : ST_SW_CMP;
			end
			ST_SW_CMP: begin
				if (sts.expired && !sts.idx_is_last) begin
					state_d = ST_MV_RD;
				end else begin
					state_d = ST_SW_RD;
				end
			end
			ST_MV_RD: state_d = ST_MV_WR;
			ST_MV_WR: state_d = ST_SW_RD;
			ST_DONE: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// sweep branches off after the item is captured
		if (state_q == ST_SCAN_RD && sts.mode == MODE_SWEEP) begin
			state_d = ST_SW_RD;
		end
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_SCAN_RD: begin
				cmd.rd_en = !sts.scan_end && sts.mode != MODE_SWEEP;
			end
			ST_SCAN_CMP: begin
				cmd.take_hit = sts.id_match;
				cmd.inc_idx = !sts.id_match;
			end
			ST_CREATE: cmd.take_new = 1'b1;
			ST_UPDATE: cmd.wr_upd = 1'b1;
			ST_SW_RD: cmd.rd_en = !sts.scan_end;
			ST_SW_CMP: begin
				cmd.sw_remove = sts.expired;
				cmd.inc_idx = !sts.expired;
			end
			ST_MV_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_last = 1'b1;
			end
			ST_MV_WR: cmd.wr_move = 1'b1;
			ST_DONE: cmd.out_load = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/bnpt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Presence table datapath
// Entry memory, item and result registers, counters and compares.
// ----------------------------------------------------------------------------
module bnpt_dp
	import bnpt_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [111:0]  s_tdata,
	input  logic [1:0]    s_tuser,
	input  logic          m_tready,
	output logic          m_tvalid,
	output logic [119:0]  m_tdata,
	output logic          m_tuser,
	input  logic          cfg_wr_en,
	input  logic [31:0]   cfg_wr_data,
	input  cmd_t          cmd,
	output sts_t          sts
);

	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);

	entry_t mem [MAX_NODES];
	entry_t rdata_q;
	entry_t entry_q;
	entry_t upd;
	entry_t fresh;

	logic [31:0] timeout_q;
	mode_t       mode_q;
	logic [7:0]  id_q;
	logic [31:0] now_q;
	logic [15:0] caps_q;
	logic [1:0]  health_q;
	logic [2:0]  opm_q;
	logic [31:0] uptime_q;
	logic [15:0] vendor_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] removed_q;
	logic [IW-1:0] slot_q;
	logic          hit_q;
	logic          out_valid_q;
	logic [119:0]  out_data_q;
	logic          out_hit_q;

	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   wr_addr;
	entry_t          wr_data;
	logic            wr_en;
	logic [31:0]     age;
	logic [IW+3:0]   slot_ext;
	logic [CW+4:0]   count_ext;
	logic [CW+4:0]   removed_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode_t'(s_tuser);
			id_q     <= s_tdata[7:0];
			now_q    <= s_tdata[39:8];
			caps_q   <= s_tdata[55:40];
			health_q <= s_tdata[57:56];
			opm_q    <= s_tdata[60:58];
			uptime_q <= s_tdata[92:61];
			vendor_q <= s_tdata[108:93];
		end
	end

	// entry memory
	assign rd_addr = cmd.rd_last ? count_q[IW-1:0] : idx_q[IW-1:0];
	assign wr_en   = cmd.wr_upd || cmd.wr_move;
	assign wr_addr = cmd.wr_upd ? slot_q : idx_q[IW-1:0];
	assign wr_data = cmd.wr_upd ? upd : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_comb begin
		upd = entry_q;
		upd.seen = now_q;
		if (mode_q == MODE_CAPS) begin
			upd.caps = entry_q.caps | caps_q;
		end else begin
			upd.health = health_q;
			upd.opm    = opm_q;
			upd.vendor = vendor_q;
			upd.uptime = uptime_q;
		end
	end

	always_comb begin
		fresh      = '0;
		fresh.id   = id_q[6:0];
		fresh.seen = now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			removed_q <= '0;
			hit_q     <= 1'b0;
			slot_q    <= '0;
		end else begin
			if (cmd.load) begin
				idx_q     <= '0;
				removed_q <= '0;
				hit_q     <= 1'b0;
				slot_q    <= '0;
			end
			if (cmd.inc_idx) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.sw_remove) begin
				count_q   <= count_q - CW'(1);
				removed_q <= removed_q + CW'(1);
			end
			if (cmd.take_hit) begin
				hit_q  <= 1'b1;
				slot_q <= idx_q[IW-1:0];
			end
			if (cmd.take_new) begin
				hit_q   <= 1'b1;
				slot_q  <= count_q[IW-1:0];
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_q <= '0;
		end else if (cmd.take_hit) begin
			entry_q <= rdata_q;
		end else if (cmd.take_new) begin
			entry_q <= fresh;
		end else if (cmd.wr_upd) begin
			entry_q <= upd;
		end
	end

	assign age = now_q - rdata_q.seen;

	assign sts.mode        = mode_q;
	assign sts.scan_end    = (idx_q >= count_q);
	assign sts.id_match    = ({1'b0, rdata_q.id} == id_q);
	assign sts.expired     = (age > timeout_q);
	assign sts.idx_is_last = ((idx_q + CW'(1)) == count_q);
	assign sts.can_create  = (id_q != 8'd0) && (id_q <= HIGHEST_NODE_ID)
		&& (count_q < CW'(MAX_NODES));
	assign sts.out_busy    = out_valid_q && !m_tready;

	// result register
	assign slot_ext    = {4'd0, slot_q};
	assign count_ext   = {5'd0, count_q};
	assign removed_ext = {5'd0, removed_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hit_q  <= hit_q;
			out_data_q <= {5'd0, entry_q.seen, entry_q.caps, entry_q.vendor,
				entry_q.uptime, entry_q.opm, entry_q.health,
				removed_ext[4:0], count_ext[4:0], slot_ext[3:0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_hit_q;

endmodule
